>>> rtl/core/wnse_pkg.sv
// Shared constants, register codes and structs of the SNR estimator.
package wnse_pkg;

    localparam int TAPS_DEFAULT       = 64;
    localparam int RING_DEPTH_DEFAULT = 8;

    localparam int SAMPLE_W   = 16;
    localparam int DB_W       = 16;
    localparam int RMS_W      = 15;
    localparam int COUNT_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_IDX_W = 6;
    localparam int WLEN_W     = 16;
    localparam int ALPHA_W    = 16;
    localparam int REF_W      = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_POWER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_INDEX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_VALUE    = 3'd4;

    localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RESET = 16'd1024;
    localparam logic [ALPHA_W-1:0] SMOOTH_WEIGHT_RESET = 16'd6554;
    localparam logic [REF_W-1:0]   REF_POWER_RESET     = 32'd536870912;

    typedef struct packed {
        logic [WLEN_W-1:0]  window_length;
        logic [ALPHA_W-1:0] smooth_weight;
        logic [REF_W-1:0]   reference_power;
    } cfg_t;

    typedef struct packed {
        logic signed [DB_W-1:0] instant_snr_db;
        logic signed [DB_W-1:0] smoothed_snr_db;
        logic [RMS_W-1:0]       noise_rms;
        logic [RMS_W-1:0]       floor_rms;
        logic [COUNT_W-1:0]     windows_seen;
    } result_t;

endpackage

>>> rtl/core/windowed_noise_snr_estimator_core.sv
// Top level of the windowed noise power and SNR estimator.
//
//  channel  | ports                                   | direction | beat
//  ---------+-----------------------------------------+-----------+---------------------------
//  s_       | s_valid, s_ready, s_sample              | in        | one audio sample
//  m_       | m_valid, m_ready, m_*_snr_db, m_*_rms,  | out       | one result per closed
//           | m_windows_seen                          |           | window
//  cfg_     | cfg_we, cfg_index, cfg_wdata            | in        | one register write
//
//  A sample beat shifts the delay line, sweeps the partial sum along the cell row,
//  then squares and accumulates the filtered sample.
//  A beat that closes a window adds the per-window sequence: 48 divide steps,
//  two log2 passes of normalising shifts plus 16 squarings each,
//  24 root steps, a scan of the ring slots and the SNR, smoothing, count and output steps.
//  While window_length is zero a beat is taken and dropped in the same cycle.
//  Reset is synchronous, active low; it clears the delay line, coefficients,
//  window state and ring, and loads the register reset values.
//  One result waiting on m_ready does not hold up the next sample beat; a second
//  closed window waits in the window unit and holds s_ready low until it drains.
module windowed_noise_snr_estimator_core #(
    parameter int TAPS       = wnse_pkg::TAPS_DEFAULT,
    parameter int RING_DEPTH = wnse_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [wnse_pkg::SAMPLE_W-1:0]     s_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [wnse_pkg::DB_W-1:0]         m_instant_snr_db,
    output logic signed [wnse_pkg::DB_W-1:0]         m_smoothed_snr_db,
    output logic [wnse_pkg::RMS_W-1:0]               m_noise_rms,
    output logic [wnse_pkg::RMS_W-1:0]               m_floor_rms,
    output logic [wnse_pkg::COUNT_W-1:0]             m_windows_seen,
    input  logic                                     cfg_we,
    input  logic [wnse_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [wnse_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

    // Accumulator width: full product plus growth over the taps
    localparam int ACC_W = 2 * wnse_pkg::SAMPLE_W + $clog2(TAPS);

    logic [wnse_pkg::WLEN_W-1:0]     wlen_reg;
    logic [wnse_pkg::ALPHA_W-1:0]    alpha_reg;
    logic [wnse_pkg::REF_W-1:0]      ref_reg;
    logic [wnse_pkg::COEF_IDX_W-1:0] cidx_reg;
    logic                            busy_reg;
    logic                            m_valid_reg;
    wnse_pkg::result_t               result_reg;

    wnse_pkg::cfg_t    cfg;
    wnse_pkg::result_t res;
    logic              coef_we;
    logic              fir_start;
    logic              fir_done;
    logic signed [ACC_W-1:0] fir_acc;
    logic              win_done;
    logic              res_valid;
    logic              res_ready;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= wnse_pkg::WINDOW_LENGTH_RESET;
            alpha_reg <= wnse_pkg::SMOOTH_WEIGHT_RESET;
            ref_reg   <= wnse_pkg::REF_POWER_RESET;
            cidx_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wnse_pkg::REG_WINDOW_LENGTH: wlen_reg  <= cfg_wdata[wnse_pkg::WLEN_W-1:0];
                wnse_pkg::REG_SMOOTH_WEIGHT: alpha_reg <= cfg_wdata[wnse_pkg::ALPHA_W-1:0];
                wnse_pkg::REG_REF_POWER:     ref_reg   <= cfg_wdata[wnse_pkg::REF_W-1:0];
                wnse_pkg::REG_COEF_INDEX:    cidx_reg  <= cfg_wdata[wnse_pkg::COEF_IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A coefficient write goes straight into the addressed cell
    assign coef_we = cfg_we && (cfg_index == wnse_pkg::REG_COEF_VALUE);

    assign cfg = '{window_length:   wlen_reg,
                   smooth_weight:   alpha_reg,
                   reference_power: ref_reg};

    // One sample in flight at a time; a zero window length drops the beat
    assign s_ready   = !busy_reg;
    assign fir_start = s_valid && s_ready && (wlen_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (fir_start) begin
            busy_reg <= 1'b1;
        end else if (win_done) begin
            busy_reg <= 1'b0;
        end
    end

    wnse_fir #(.TAPS(TAPS), .ACC_W(ACC_W)) u_fir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (fir_start),
        .sample    (s_sample),
        .coef_we   (coef_we),
        .coef_idx  (cidx_reg),
        .coef_data (cfg_wdata[wnse_pkg::SAMPLE_W-1:0]),
        .done      (fir_done),
        .acc       (fir_acc)
    );

    wnse_win #(.RING_DEPTH(RING_DEPTH), .ACC_W(ACC_W)) u_win (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .fir_valid (fir_done),
        .fir_acc   (fir_acc),
        .done      (win_done),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            result_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_instant_snr_db  = result_reg.instant_snr_db;
    assign m_smoothed_snr_db = result_reg.smoothed_snr_db;
    assign m_noise_rms       = result_reg.noise_rms;
    assign m_floor_rms       = result_reg.floor_rms;
    assign m_windows_seen    = result_reg.windows_seen;

endmodule

>>> rtl/core/wnse_cell.sv
// One FIR cell: delay tap, coefficient and a multiply-add on the passing partial sum.
module wnse_cell #(
    parameter int ACC_W = 38
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   shift_en,
    input  logic signed [wnse_pkg::SAMPLE_W-1:0]   x_in,
    input  logic                                   coef_we,
    input  logic signed [wnse_pkg::SAMPLE_W-1:0]   coef_data,
    input  logic                                   go_in,
    input  logic signed [ACC_W-1:0]                psum_in,
    output logic signed [wnse_pkg::SAMPLE_W-1:0]   x_out,
    output logic                                   go_out,
    output logic signed [ACC_W-1:0]                psum_out
);

    logic signed [wnse_pkg::SAMPLE_W-1:0]   x_reg;
    logic signed [wnse_pkg::SAMPLE_W-1:0]   coef_reg;
    logic                                   go_reg;
    logic signed [ACC_W-1:0]                psum_reg;
    logic signed [2*wnse_pkg::SAMPLE_W-1:0] prod;
    logic signed [ACC_W-1:0]                psum_next;

    assign prod      = x_reg * coef_reg;
    assign psum_next = psum_in + ACC_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg    <= '0;
            coef_reg <= '0;
            go_reg   <= 1'b0;
        end else begin
            if (shift_en) begin
                x_reg <= x_in;
            end
            if (coef_we) begin
                coef_reg <= coef_data;
            end
            go_reg <= go_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (go_in) begin
            psum_reg <= psum_next;
        end
    end

    assign x_out    = x_reg;
    assign go_out   = go_reg;
    assign psum_out = psum_reg;

endmodule

>>> rtl/core/wnse_fir.sv
// Row of FIR cells: shared delay line shift and a partial sum swept along the row.
module wnse_fir #(
    parameter int TAPS  = wnse_pkg::TAPS_DEFAULT,
    parameter int ACC_W = 38
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [wnse_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  coef_we,
    input  logic [wnse_pkg::COEF_IDX_W-1:0]       coef_idx,
    input  logic signed [wnse_pkg::SAMPLE_W-1:0]  coef_data,
    output logic                                  done,
    output logic signed [ACC_W-1:0]               acc
);

    logic                                 start_reg;
    logic signed [wnse_pkg::SAMPLE_W-1:0] x_link [TAPS];
    logic                                 go_link [TAPS];
    logic signed [ACC_W-1:0]              psum_link [TAPS];

    // The sweep starts in the cycle after the shift so cell 0 sees the new sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b0;
        end else begin
            start_reg <= start;
        end
    end

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic                                 hit;
        logic signed [wnse_pkg::SAMPLE_W-1:0] x_src;
        logic                                 go_src;
        logic signed [ACC_W-1:0]              psum_src;

        assign hit = coef_we && (32'(coef_idx) == 32'(k));

        if (k == 0) begin : g_head
            assign x_src    = sample;
            assign go_src   = start_reg;
            assign psum_src = '0;
        end else begin : g_body
            assign x_src    = x_link[k-1];
            assign go_src   = go_link[k-1];
            assign psum_src = psum_link[k-1];
        end

        wnse_cell #(.ACC_W(ACC_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (start),
            .x_in      (x_src),
            .coef_we   (hit),
            .coef_data (coef_data),
            .go_in     (go_src),
            .psum_in   (psum_src),
            .x_out     (x_link[k]),
            .go_out    (go_link[k]),
            .psum_out  (psum_link[k])
        );
    end

    assign done = go_link[TAPS-1];
    assign acc  = psum_link[TAPS-1];

endmodule

>>> rtl/core/wnse_win.sv
// Window power accumulation and per-window maths: divide, log2, SNR, root, smoothing, ring.
module wnse_win #(
    parameter int RING_DEPTH = wnse_pkg::RING_DEPTH_DEFAULT,
    parameter int ACC_W      = 38
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wnse_pkg::cfg_t          cfg,
    input  logic                    fir_valid,
    input  logic signed [ACC_W-1:0] fir_acc,
    output logic                    done,
    output logic                    res_valid,
    input  logic                    res_ready,
    output wnse_pkg::result_t       res
);

    localparam int RP_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [RP_W-1:0] RP_LAST = RP_W'(RING_DEPTH - 1);
    localparam logic [wnse_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic signed [18:0] DB_PER_LOG2 = 19'sd197283;

    localparam logic [3:0] W_IDLE  = 4'd0;
    localparam logic [3:0] W_SQ    = 4'd1;
    localparam logic [3:0] W_DIV   = 4'd2;
    localparam logic [3:0] W_LNORM = 4'd3;
    localparam logic [3:0] W_LSQ   = 4'd4;
    localparam logic [3:0] W_SNR   = 4'd5;
    localparam logic [3:0] W_SQRT  = 4'd6;
    localparam logic [3:0] W_EMA1  = 4'd7;
    localparam logic [3:0] W_EMA2  = 4'd8;
    localparam logic [3:0] W_CNT   = 4'd9;
    localparam logic [3:0] W_SCAN  = 4'd10;
    localparam logic [3:0] W_OUT   = 4'd11;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -48'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic [3:0]         state_reg;
    logic signed [15:0] y_reg;
    logic [47:0]        psum_reg;
    logic [15:0]        fill_reg;
    logic [47:0]        q_reg;
    logic [15:0]        r_reg;
    logic [5:0]         cnt_reg;
    logic [47:0]        lx_reg;
    logic [5:0]         ln_reg;
    logic [31:0]        lm_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         lcnt_reg;
    logic               lsel_reg;
    logic [21:0]        logr_reg;
    logic signed [22:0] d_reg;
    logic signed [15:0] snr_reg;
    logic [23:0]        sr_reg;
    logic [4:0]         sbit_reg;
    logic [14:0]        rms_reg;
    logic               est_reg;
    logic signed [15:0] smooth_reg;
    logic signed [33:0] proda_reg;
    logic [23:0]        wc_reg;
    logic [RP_W-1:0]    ptr_reg;
    logic [14:0]        ring_reg [RING_DEPTH];
    logic [RP_W-1:0]    idx_reg;
    logic [14:0]        fl_reg;

    logic signed [ACC_W:0] y_round;
    logic signed [ACC_W:0] y_shift;
    logic signed [31:0]    y_sq;
    logic [47:0]           psum_next;
    logic [15:0]           fill_next;
    logic                  close;
    logic [16:0]           r_shift;
    logic                  r_ge;
    logic [16:0]           r_sub;
    logic [47:0]           ref_b;
    logic [47:0]           mean_b;
    logic [63:0]           lsq;
    logic [32:0]           s33;
    logic [15:0]           frac_next;
    logic [21:0]           log_res;
    logic signed [22:0]    d_next;
    logic signed [41:0]    snr_prod;
    logic signed [41:0]    snr_shift;
    logic signed [15:0]    snr_next;
    logic [23:0]           sr_try;
    logic [47:0]           sr_sq;
    logic [23:0]           sr_next;
    logic [14:0]           rms_next;
    logic signed [33:0]    proda_next;
    logic [16:0]           weight;
    logic signed [35:0]    ema_sum;
    logic signed [35:0]    ema_shift;
    logic signed [15:0]    ema_next;
    logic [14:0]           ring_v;
    logic                  take;

    assign y_round   = (ACC_W+1)'(fir_acc) + (ACC_W+1)'(17'sd16384);
    assign y_shift   = y_round >>> 15;
    assign y_sq      = y_reg * y_reg;
    assign psum_next = psum_reg + 48'($unsigned(y_sq));
    assign fill_next = fill_reg + 16'd1;
    assign close     = (fill_next == 16'd0) || (fill_next >= cfg.window_length);

    assign r_shift = {r_reg, q_reg[47]};
    assign r_ge    = r_shift >= {1'b0, cfg.window_length};
    assign r_sub   = r_shift - {1'b0, cfg.window_length};

    assign ref_b  = (cfg.reference_power == '0) ? 48'd1 : 48'(cfg.reference_power);
    assign mean_b = (q_reg == '0) ? 48'd1 : q_reg;

    assign lsq       = lm_reg * lm_reg;
    assign s33       = lsq[63:31];
    assign frac_next = frac_reg | (s33[32] ? (16'd1 << lcnt_reg) : 16'd0);
    assign log_res   = {ln_reg, frac_next};
    assign d_next    = $signed({1'b0, logr_reg}) - $signed({1'b0, log_res});

    assign snr_prod  = 42'(d_reg) * 42'(DB_PER_LOG2);
    assign snr_shift = (snr_prod + 42'sd8388608) >>> 24;
    assign snr_next  = sat16(48'(snr_shift));

    assign sr_try   = sr_reg | (24'd1 << sbit_reg);
    assign sr_sq    = sr_try * sr_try;
    assign sr_next  = (sr_sq <= q_reg) ? sr_try : sr_reg;
    assign rms_next = (sr_next > 24'd32767) ? 15'h7FFF : sr_next[14:0];

    assign proda_next = 34'($signed({1'b0, cfg.smooth_weight})) * 34'(snr_reg);
    assign weight     = 17'h10000 - {1'b0, cfg.smooth_weight};
    assign ema_sum    = 36'(proda_reg) + 36'($signed({1'b0, weight})) * 36'(smooth_reg);
    assign ema_shift  = (ema_sum + 36'sd32768) >>> 16;
    assign ema_next   = sat16(48'(ema_shift));

    assign ring_v = ring_reg[idx_reg];
    assign take   = (24'(idx_reg) < wc_reg) && (ring_v != '0) &&
                    ((fl_reg == '0) || (ring_v < fl_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= W_IDLE;
            psum_reg   <= '0;
            fill_reg   <= '0;
            est_reg    <= 1'b0;
            smooth_reg <= '0;
            wc_reg     <= '0;
            ptr_reg    <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                W_IDLE: begin
                    if (fir_valid) begin
                        y_reg     <= sat16(48'(y_shift));
                        state_reg <= W_SQ;
                    end
                end
                W_SQ: begin
                    if (close) begin
                        q_reg     <= psum_next;
                        r_reg     <= '0;
                        cnt_reg   <= '0;
                        psum_reg  <= '0;
                        fill_reg  <= '0;
                        state_reg <= W_DIV;
                    end else begin
                        psum_reg  <= psum_next;
                        fill_reg  <= fill_next;
                        state_reg <= W_IDLE;
                    end
                end
                W_DIV: begin
                    q_reg   <= {q_reg[46:0], r_ge};
                    r_reg   <= r_ge ? r_sub[15:0] : r_shift[15:0];
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47) begin
                        lx_reg    <= ref_b;
                        ln_reg    <= 6'd47;
                        lsel_reg  <= 1'b0;
                        state_reg <= W_LNORM;
                    end
                end
                W_LNORM: begin
                    if (lx_reg[47]) begin
                        lm_reg    <= lx_reg[47:16];
                        frac_reg  <= '0;
                        lcnt_reg  <= 4'd15;
                        state_reg <= W_LSQ;
                    end else begin
                        lx_reg <= lx_reg << 1;
                        ln_reg <= ln_reg - 6'd1;
                    end
                end
                W_LSQ: begin
                    lm_reg   <= s33[32] ? s33[32:1] : s33[31:0];
                    frac_reg <= frac_next;
                    lcnt_reg <= lcnt_reg - 4'd1;
                    if (lcnt_reg == 4'd0) begin
                        if (!lsel_reg) begin
                            logr_reg  <= log_res;
                            lx_reg    <= mean_b;
                            ln_reg    <= 6'd47;
                            lsel_reg  <= 1'b1;
                            state_reg <= W_LNORM;
                        end else begin
                            d_reg     <= d_next;
                            state_reg <= W_SNR;
                        end
                    end
                end
                W_SNR: begin
                    snr_reg   <= snr_next;
                    sr_reg    <= '0;
                    sbit_reg  <= 5'd23;
                    state_reg <= W_SQRT;
                end
                W_SQRT: begin
                    sr_reg   <= sr_next;
                    sbit_reg <= sbit_reg - 5'd1;
                    if (sbit_reg == 5'd0) begin
                        rms_reg           <= rms_next;
                        ring_reg[ptr_reg] <= rms_next;
                        state_reg         <= W_EMA1;
                    end
                end
                W_EMA1: begin
                    if (!est_reg) begin
                        smooth_reg <= snr_reg;
                        est_reg    <= 1'b1;
                        state_reg  <= W_CNT;
                    end else begin
                        proda_reg <= proda_next;
                        state_reg <= W_EMA2;
                    end
                end
                W_EMA2: begin
                    smooth_reg <= ema_next;
                    state_reg  <= W_CNT;
                end
                W_CNT: begin
                    // hold count and ring slot once saturated
                    if (wc_reg != COUNT_MAX) begin
                        wc_reg  <= wc_reg + 24'd1;
                        ptr_reg <= (ptr_reg == RP_LAST) ? '0 : ptr_reg + RP_W'(1);
                    end
                    idx_reg   <= '0;
                    fl_reg    <= '0;
                    state_reg <= W_SCAN;
                end
                W_SCAN: begin
                    if (take) begin
                        fl_reg <= ring_v;
                    end
                    if (idx_reg == RP_LAST) begin
                        state_reg <= W_OUT;
                    end else begin
                        idx_reg <= idx_reg + RP_W'(1);
                    end
                end
                W_OUT: begin
                    if (res_ready) begin
                        state_reg <= W_IDLE;
                    end
                end
                default: begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    assign done      = ((state_reg == W_SQ) && !close) || ((state_reg == W_OUT) && res_ready);
    assign res_valid = (state_reg == W_OUT);
    assign res       = '{instant_snr_db:  snr_reg,
                         smoothed_snr_db: smooth_reg,
                         noise_rms:       rms_reg,
                         floor_rms:       fl_reg,
                         windows_seen:    wc_reg};

endmodule

>>> rtl/core/wnse_chk.sv
// Port-level checks of the SNR estimator, bound to the top level.
module wnse_chk (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [wnse_pkg::DB_W-1:0]     m_instant_snr_db,
    input logic signed [wnse_pkg::DB_W-1:0]     m_smoothed_snr_db,
    input logic [wnse_pkg::RMS_W-1:0]           m_noise_rms,
    input logic [wnse_pkg::RMS_W-1:0]           m_floor_rms,
    input logic [wnse_pkg::COUNT_W-1:0]         m_windows_seen
);

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_instant_snr_db) &&
        $stable(m_smoothed_snr_db) && $stable(m_noise_rms) &&
        $stable(m_floor_rms) && $stable(m_windows_seen))
        else $error("stalled result changed");

    // Every result closes at least one window
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_windows_seen != '0)
        else $error("result with zero window count");

    // The current window sits in the ring, so a nonzero RMS bounds the floor
    a_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_noise_rms != '0) |-> (m_floor_rms != '0) && (m_floor_rms <= m_noise_rms))
        else $error("floor RMS above window RMS");

endmodule

bind windowed_noise_snr_estimator_core wnse_chk u_wnse_chk (.*);
